// ===== hdl/shr_pkg.sv =====
`default_nettype none
package shr_pkg;

    localparam int IDX_W      = 10;
    localparam int FUNC_W     = 2;
    localparam int PERIOD_W   = 2;
    localparam int CNT_W      = 32;
    localparam int HIST_W     = 64;
    localparam int ONES_W     = 7;
    localparam int NCOUNT_W   = 11;
    localparam int BYTES      = HIST_W / 8;
    localparam int QUEUE_AW   = 1;
    localparam int QUEUE_DEPTH = 2 ** QUEUE_AW;

    localparam logic [NCOUNT_W-1:0] NCOUNT_RESET = 11'd1024;

    localparam logic [FUNC_W-1:0] FUNC_RECORD       = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_DISABLE      = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR_PERIOD = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_QUERY        = 2'd3;

    typedef enum logic [2:0] {
        OP_RECORD       = 3'd0,
        OP_DISABLE      = 3'd1,
        OP_CLEAR_PERIOD = 3'd2,
        OP_QUERY        = 3'd3,
        OP_REJECT       = 3'd4
    } shr_op_t;

    typedef struct packed {
        shr_op_t               op;
        logic [IDX_W-1:0]      idx;
        logic                  fired;
        logic [PERIOD_W-1:0]   period;
    } shr_item_t;

    typedef struct packed {
        logic init_busy;
    } shr_back_status_t;

endpackage
`default_nettype wire

// ===== hdl/shr_front.sv =====
`default_nettype none
module shr_front #(
    parameter int MAX_NEURONS = 1024
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [shr_pkg::FUNC_W-1:0]        s_func,
    input  logic [shr_pkg::IDX_W-1:0]         s_neuron_index,
    input  logic                              s_fired_value,
    input  logic [shr_pkg::PERIOD_W-1:0]      s_period_select,
    input  logic                              cfg_wr_en,
    input  logic [shr_pkg::NCOUNT_W-1:0]      cfg_wr_data,
    input  logic                              q_full,
    input  shr_pkg::shr_back_status_t         back_status,
    output logic                              push,
    output shr_pkg::shr_item_t                push_item
);
    import shr_pkg::*;

    logic [NCOUNT_W-1:0] neuron_count_reg, neuron_count_next;
    logic [31:0]         limit;
    logic                in_range;

    always_comb begin
        neuron_count_next = cfg_wr_en ? cfg_wr_data : neuron_count_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            neuron_count_reg <= NCOUNT_RESET;
        end else begin
            neuron_count_reg <= neuron_count_next;
        end
    end

    assign limit    = (32'(neuron_count_reg) > 32'(MAX_NEURONS)) ? 32'(MAX_NEURONS)
                                                                 : 32'(neuron_count_reg);
    assign in_range = 32'(s_neuron_index) < limit;

    assign s_ready = !q_full && !back_status.init_busy;
    assign push    = s_valid && s_ready;

    always_comb begin
        push_item.idx    = s_neuron_index;
        push_item.fired  = s_fired_value;
        push_item.period = s_period_select;
        case (s_func)
            FUNC_RECORD: begin
                push_item.op = in_range ? OP_RECORD : OP_REJECT;
            end
            FUNC_DISABLE: begin
                push_item.op = in_range ? OP_DISABLE : OP_REJECT;
            end
            FUNC_CLEAR_PERIOD: begin
                push_item.op = OP_CLEAR_PERIOD;
            end
            FUNC_QUERY: begin
                push_item.op = in_range ? OP_QUERY : OP_REJECT;
            end
            default: begin
                push_item.op = OP_REJECT;
            end
        endcase
    end

endmodule
`default_nettype wire

// ===== hdl/shr_queue.sv =====
`default_nettype none
module shr_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  shr_pkg::shr_item_t  push_item,
    output logic                full,
    output logic                q_valid,
    output shr_pkg::shr_item_t  q_item,
    input  logic                q_pop
);
    import shr_pkg::*;

    shr_item_t             entry_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_AW:0]     count_reg, count_next;

    assign full    = count_reg == (QUEUE_AW + 1)'(QUEUE_DEPTH);
    assign q_valid = count_reg != '0;
    assign q_item  = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push  ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = q_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !q_pop) begin
            count_next = count_reg + 1'b1;
        end else if (!push && q_pop) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule
`default_nettype wire

// ===== hdl/shr_back.sv =====
`default_nettype none
module shr_back #(
    parameter int MAX_NEURONS = 1024,
    parameter int HIST_LEN    = 64,
    parameter int PERIODS     = 4
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              q_valid,
    input  shr_pkg::shr_item_t                q_item,
    output logic                              q_pop,
    output shr_pkg::shr_back_status_t         back_status,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic                              m_out_of_range,
    output logic                              m_status_now,
    output logic [shr_pkg::HIST_W-1:0]        m_history_word,
    output logic [shr_pkg::ONES_W-1:0]        m_history_ones,
    output logic [shr_pkg::CNT_W-1:0]         m_period_count
);
    import shr_pkg::*;

    localparam int ADDR_W = (MAX_NEURONS > 1) ? $clog2(MAX_NEURONS) : 1;
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(MAX_NEURONS - 1);

    typedef enum logic [6:0] {
        ST_CLEAR  = 7'b0000001,
        ST_IDLE   = 7'b0000010,
        ST_READ   = 7'b0000100,
        ST_MODIFY = 7'b0001000,
        ST_POPC   = 7'b0010000,
        ST_WALK   = 7'b0100000,
        ST_RESULT = 7'b1000000
    } state_t;

    state_t                state_reg, state_next;
    shr_op_t               op_reg, op_next;
    logic [ADDR_W-1:0]     addr_reg, addr_next;
    logic                  fired_reg, fired_next;
    logic [PERIOD_W-1:0]   period_reg, period_next;
    logic [ADDR_W-1:0]     walk_reg, walk_next;

    logic                  res_oor_reg, res_oor_next;
    logic                  res_status_reg, res_status_next;
    logic [HIST_W-1:0]     res_hist_reg, res_hist_next;
    logic [CNT_W-1:0]      res_count_reg, res_count_next;
    logic [3:0]            res_bytes_reg [BYTES];
    logic [3:0]            res_bytes_next [BYTES];

    logic                  m_valid_reg, m_valid_next;
    logic                  m_oor_reg, m_status_reg;
    logic [HIST_W-1:0]     m_hist_reg;
    logic [ONES_W-1:0]     m_ones_reg, ones_sum;
    logic [CNT_W-1:0]      m_count_reg;

    logic [HIST_LEN:0]     nmem [MAX_NEURONS];
    logic [HIST_LEN:0]     nrd_reg;
    logic                  nmem_we;
    logic [HIST_LEN:0]     nmem_wdata;
    logic [ADDR_W-1:0]     mem_waddr;
    logic [PERIODS-1:0]    cnt_we;
    logic [CNT_W-1:0]      cnt_wdata [PERIODS];
    logic [CNT_W-1:0]      cnt_rd_reg [PERIODS];

    logic [HIST_LEN-1:0]   hist_cur, hist_new;
    logic                  status_new;
    logic [CNT_W-1:0]      cnt_new [PERIODS];
    logic [CNT_W-1:0]      sel_count;
    logic                  load_out;

    function automatic logic [3:0] ones8(input logic [7:0] v);
        logic [3:0] n;
        n = '0;
        for (int i = 0; i < 8; i++) begin
            n = n + 4'(v[i]);
        end
        return n;
    endfunction

    // neuron word: status above history
    always_ff @(posedge aclk) begin
        if (nmem_we) begin
            nmem[mem_waddr] <= nmem_wdata;
        end
        nrd_reg <= nmem[addr_reg];
    end

    for (genvar p = 0; p < PERIODS; p++) begin : g_cnt
        logic [CNT_W-1:0] cnt_mem [MAX_NEURONS];
        always_ff @(posedge aclk) begin
            if (cnt_we[p]) begin
                cnt_mem[mem_waddr] <= cnt_wdata[p];
            end
            cnt_rd_reg[p] <= cnt_mem[addr_reg];
        end
    end

    assign hist_cur = nrd_reg[HIST_LEN-1:0];

    always_comb begin
        hist_new   = hist_cur;
        status_new = nrd_reg[HIST_LEN];
        for (int p = 0; p < PERIODS; p++) begin
            cnt_new[p] = cnt_rd_reg[p];
        end
        case (op_reg)
            OP_RECORD: begin
                hist_new   = HIST_LEN'({hist_cur, fired_reg});
                status_new = fired_reg;
                for (int p = 0; p < PERIODS; p++) begin
                    cnt_new[p] = cnt_rd_reg[p] + CNT_W'(fired_reg);
                end
            end
            OP_DISABLE: begin
                status_new = 1'b0;
                for (int p = 0; p < PERIODS; p++) begin
                    cnt_new[p] = '0;
                end
            end
            default: begin
            end
        endcase
        sel_count = '0;
        for (int p = 0; p < PERIODS; p++) begin
            if (period_reg == PERIOD_W'(p)) begin
                sel_count = cnt_new[p];
            end
        end
    end

    always_comb begin
        mem_waddr  = (state_reg == ST_CLEAR || state_reg == ST_WALK) ? walk_reg : addr_reg;
        nmem_we    = (state_reg == ST_CLEAR) ||
                     (state_reg == ST_MODIFY && op_reg != OP_QUERY);
        nmem_wdata = (state_reg == ST_CLEAR) ? '0 : {status_new, hist_new};
        for (int p = 0; p < PERIODS; p++) begin
            cnt_we[p]    = (state_reg == ST_CLEAR) ||
                           (state_reg == ST_MODIFY &&
                            (op_reg == OP_RECORD || op_reg == OP_DISABLE)) ||
                           (state_reg == ST_WALK && period_reg == PERIOD_W'(p));
            cnt_wdata[p] = (state_reg == ST_MODIFY) ? cnt_new[p] : '0;
        end
    end

    always_comb begin
        ones_sum = '0;
        for (int b = 0; b < BYTES; b++) begin
            ones_sum = ones_sum + ONES_W'(res_bytes_reg[b]);
        end
    end

    assign q_pop    = (state_reg == ST_IDLE) && q_valid;
    assign load_out = (state_reg == ST_RESULT) && (!m_valid_reg || m_ready);

    always_comb begin
        state_next      = state_reg;
        op_next         = op_reg;
        addr_next       = addr_reg;
        fired_next      = fired_reg;
        period_next     = period_reg;
        walk_next       = walk_reg;
        res_oor_next    = res_oor_reg;
        res_status_next = res_status_reg;
        res_hist_next   = res_hist_reg;
        res_count_next  = res_count_reg;
        for (int b = 0; b < BYTES; b++) begin
            res_bytes_next[b] = res_bytes_reg[b];
        end
        case (state_reg)
            ST_CLEAR: begin
                walk_next = walk_reg + 1'b1;
                if (walk_reg == LAST_ADDR) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (q_valid) begin
                    op_next         = q_item.op;
                    addr_next       = ADDR_W'(q_item.idx);
                    fired_next      = q_item.fired;
                    period_next     = q_item.period;
                    walk_next       = '0;
                    res_oor_next    = q_item.op == OP_REJECT;
                    res_status_next = 1'b0;
                    res_hist_next   = '0;
                    res_count_next  = '0;
                    for (int b = 0; b < BYTES; b++) begin
                        res_bytes_next[b] = '0;
                    end
                    if (q_item.op == OP_REJECT) begin
                        state_next = ST_RESULT;
                    end else if (q_item.op == OP_CLEAR_PERIOD) begin
                        state_next = (32'(q_item.period) < PERIODS) ? ST_WALK : ST_RESULT;
                    end else begin
                        state_next = ST_READ;
                    end
                end
            end
            ST_READ: begin
                state_next = ST_MODIFY;
            end
            ST_MODIFY: begin
                res_status_next = status_new;
                res_hist_next   = HIST_W'(hist_new);
                res_count_next  = sel_count;
                state_next      = ST_POPC;
            end
            ST_POPC: begin
                for (int b = 0; b < BYTES; b++) begin
                    res_bytes_next[b] = ones8(res_hist_reg[8*b +: 8]);
                end
                state_next = ST_RESULT;
            end
            ST_WALK: begin
                walk_next = walk_reg + 1'b1;
                if (walk_reg == LAST_ADDR) begin
                    state_next = ST_RESULT;
                end
            end
            ST_RESULT: begin
                if (load_out) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (m_ready) begin
            m_valid_next = 1'b0;
        end
        if (load_out) begin
            m_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            walk_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            walk_reg    <= walk_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg         <= op_next;
        addr_reg       <= addr_next;
        fired_reg      <= fired_next;
        period_reg     <= period_next;
        res_oor_reg    <= res_oor_next;
        res_status_reg <= res_status_next;
        res_hist_reg   <= res_hist_next;
        res_count_reg  <= res_count_next;
        for (int b = 0; b < BYTES; b++) begin
            res_bytes_reg[b] <= res_bytes_next[b];
        end
        if (load_out) begin
            m_oor_reg    <= res_oor_reg;
            m_status_reg <= res_status_reg;
            m_hist_reg   <= res_hist_reg;
            m_ones_reg   <= ones_sum;
            m_count_reg  <= res_count_reg;
        end
    end

    assign back_status.init_busy = state_reg == ST_CLEAR;

    assign m_valid        = m_valid_reg;
    assign m_out_of_range = m_oor_reg;
    assign m_status_now   = m_status_reg;
    assign m_history_word = m_hist_reg;
    assign m_history_ones = m_ones_reg;
    assign m_period_count = m_count_reg;

`ifndef SYNTHESIS
    a_pop_leaves_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |=> state_reg != ST_IDLE)
        else $error("back did not leave idle after taking a queue entry");

    a_reject_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_oor_reg) |->
            (m_hist_reg == '0 && m_count_reg == '0 && !m_status_reg && m_ones_reg == '0))
        else $error("out-of-range beat carries non-zero fields");

    a_walk_counters_only: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_WALK |-> !nmem_we)
        else $error("neuron word written during period walk");

    a_ones_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> m_ones_reg <= ONES_W'(HIST_LEN))
        else $error("history ones above history length");

    a_load_from_result: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg) == ST_RESULT)
        else $error("result beat raised outside result state");
`endif

endmodule
`default_nettype wire

// ===== hdl/spike_history_recorder_unit.sv =====
// Spike history recorder: per-neuron status, history shift word and
// per-period fire counters.
// s_ channel (valid/ready) carries one op per beat: record, disable,
// period reset or query. m_ channel (valid/ready) returns one beat per op.
// cfg_wr_en/cfg_wr_data write neuron_count at once; write only while idle.
// Record, disable and query pass through queue pop, read, modify/write-back,
// popcount and output load, steps set by the registered memory read and the
// split popcount; the back end works on one op at a time.
// Out-of-range ops: queue pop then output load, no memory access.
// Period reset walks every entry, one counter entry cleared a cycle.
// A two-beat queue lets ops be taken while the back end works or a result
// waits. A stalled m_ channel holds its beat; the back end stops only when
// it has the next result ready, and the queue then fills and drops s_ready.
// After reset s_ready stays low while every memory entry is cleared;
// neuron_count returns to 1024.
`default_nettype none
module spike_history_recorder_unit #(
    parameter int MAX_NEURONS = 1024,
    parameter int HIST_LEN    = 64,
    parameter int PERIODS     = 4
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [shr_pkg::FUNC_W-1:0]        s_func,
    input  logic [shr_pkg::IDX_W-1:0]         s_neuron_index,
    input  logic                              s_fired_value,
    input  logic [shr_pkg::PERIOD_W-1:0]      s_period_select,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic                              m_out_of_range,
    output logic                              m_status_now,
    output logic [shr_pkg::HIST_W-1:0]        m_history_word,
    output logic [shr_pkg::ONES_W-1:0]        m_history_ones,
    output logic [shr_pkg::CNT_W-1:0]         m_period_count,
    input  logic                              cfg_wr_en,
    input  logic [shr_pkg::NCOUNT_W-1:0]      cfg_wr_data
);
    import shr_pkg::*;

    logic              push, q_full, q_valid, q_pop;
    shr_item_t         push_item, q_item;
    shr_back_status_t  back_status;

    shr_front #(
        .MAX_NEURONS (MAX_NEURONS)
    ) u_front (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_func          (s_func),
        .s_neuron_index  (s_neuron_index),
        .s_fired_value   (s_fired_value),
        .s_period_select (s_period_select),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .q_full          (q_full),
        .back_status     (back_status),
        .push            (push),
        .push_item       (push_item)
    );

    shr_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_item (push_item),
        .full      (q_full),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .q_pop     (q_pop)
    );

    shr_back #(
        .MAX_NEURONS (MAX_NEURONS),
        .HIST_LEN    (HIST_LEN),
        .PERIODS     (PERIODS)
    ) u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .q_valid        (q_valid),
        .q_item         (q_item),
        .q_pop          (q_pop),
        .back_status    (back_status),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_out_of_range (m_out_of_range),
        .m_status_now   (m_status_now),
        .m_history_word (m_history_word),
        .m_history_ones (m_history_ones),
        .m_period_count (m_period_count)
    );

endmodule
`default_nettype wire

// ===== tb/spike_history_recorder_unit_test.sv =====
`timescale 1ns / 100ps

module spike_history_recorder_unit_test;
    import shr_pkg::*;

    localparam int NEURONS = 1024;
    localparam int SLOTS   = 4;

    class spike_tally;
        typedef struct packed {
            logic              out_of_range;
            logic              status_now;
            logic [HIST_W-1:0] history_word;
            logic [ONES_W-1:0] history_ones;
            logic [CNT_W-1:0]  period_count;
        } reply_t;

        logic [HIST_W-1:0]   history [NEURONS];
        logic                fired_now [NEURONS];
        logic [CNT_W-1:0]    fires [NEURONS][SLOTS];
        logic [NCOUNT_W-1:0] in_use;
        reply_t              replies_due [$];
        int                  errors;

        function new();
            for (int n = 0; n < NEURONS; n++) begin
                history[n] = '0;
                fired_now[n] = 1'b0;
                for (int p = 0; p < SLOTS; p++) begin
                    fires[n][p] = '0;
                end
            end
            in_use = NCOUNT_RESET;
            errors = 0;
        endfunction

        function void set_count(logic [NCOUNT_W-1:0] v);
            in_use = v;
        endfunction

        function void note_op(logic [FUNC_W-1:0] func, logic [IDX_W-1:0] idx, logic fired,
                              logic [PERIOD_W-1:0] period);
            reply_t r;
            int     lim;
            r = '0;
            lim = (in_use > NEURONS) ? NEURONS : in_use;
            if (func == FUNC_CLEAR_PERIOD) begin
                // walks every entry, in range or not
                for (int n = 0; n < NEURONS; n++) begin
                    fires[n][period] = '0;
                end
            end else if (idx >= lim) begin
                r.out_of_range = 1'b1;
            end else begin
                if (func == FUNC_RECORD) begin
                    history[idx] = {history[idx][HIST_W-2:0], fired};
                    fired_now[idx] = fired;
                    if (fired) begin
                        for (int p = 0; p < SLOTS; p++) begin
                            fires[idx][p] = fires[idx][p] + 1;
                        end
                    end
                end else if (func == FUNC_DISABLE) begin
                    // history survives a disable
                    for (int p = 0; p < SLOTS; p++) begin
                        fires[idx][p] = '0;
                    end
                    fired_now[idx] = 1'b0;
                end
                r.status_now   = fired_now[idx];
                r.history_word = history[idx];
                r.history_ones = ONES_W'($countones(history[idx]));
                r.period_count = fires[idx][period];
            end
            replies_due.push_back(r);
        endfunction

        function void compare(string field, logic [63:0] want, logic [63:0] got);
            if (want !== got) begin
                $display("%0t: %s expected %0h actual %0h", $time, field, want, got);
                errors++;
            end
        endfunction

        function void check_beat(logic oor, logic st, logic [HIST_W-1:0] hw,
                                 logic [ONES_W-1:0] ho, logic [CNT_W-1:0] pc);
            reply_t r;
            if (replies_due.size() == 0) begin
                $display("%0t: result beat with nothing outstanding", $time);
                errors++;
                return;
            end
            r = replies_due.pop_front();
            compare("out_of_range", 64'(r.out_of_range), 64'(oor));
            compare("status_now", 64'(r.status_now), 64'(st));
            compare("history_word", r.history_word, hw);
            compare("history_ones", 64'(r.history_ones), 64'(ho));
            compare("period_count", 64'(r.period_count), 64'(pc));
        endfunction

        function int outstanding();
            return replies_due.size();
        endfunction
    endclass

    logic                 aclk = 1'b0;
    logic                 aresetn;
    logic                 s_valid;
    logic                 s_ready;
    logic [FUNC_W-1:0]    s_func;
    logic [IDX_W-1:0]     s_neuron_index;
    logic                 s_fired_value;
    logic [PERIOD_W-1:0]  s_period_select;
    logic                 m_valid;
    logic                 m_ready;
    logic                 m_out_of_range;
    logic                 m_status_now;
    logic [HIST_W-1:0]    m_history_word;
    logic [ONES_W-1:0]    m_history_ones;
    logic [CNT_W-1:0]     m_period_count;
    logic                 cfg_wr_en;
    logic [NCOUNT_W-1:0]  cfg_wr_data;

    logic                 choke_req;
    logic [IDX_W-1:0]     hot [6] = '{10'd0, 10'd1, 10'd511, 10'd512, 10'd1022, 10'd1023};
    spike_tally           board;

    spike_history_recorder_unit u_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_func          (s_func),
        .s_neuron_index  (s_neuron_index),
        .s_fired_value   (s_fired_value),
        .s_period_select (s_period_select),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_out_of_range  (m_out_of_range),
        .m_status_now    (m_status_now),
        .m_history_word  (m_history_word),
        .m_history_ones  (m_history_ones),
        .m_period_count  (m_period_count),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    task automatic push_op(input logic [FUNC_W-1:0] func, input logic [IDX_W-1:0] idx,
                           input logic fired, input logic [PERIOD_W-1:0] period);
        @(negedge aclk);
        s_valid = 1'b1;
        s_func = func;
        s_neuron_index = idx;
        s_fired_value = fired;
        s_period_select = period;
        do @(posedge aclk); while (!s_ready);
        board.note_op(func, idx, fired, period);
    endtask

    // valid low with junk on the payload
    task automatic pause_sender(input int cycles);
        @(negedge aclk);
        s_valid = 1'b0;
        s_func = FUNC_W'($urandom);
        s_neuron_index = IDX_W'($urandom);
        s_fired_value = 1'($urandom);
        s_period_select = PERIOD_W'($urandom);
        repeat (cycles) @(posedge aclk);
    endtask

    task automatic write_neuron_count(input logic [NCOUNT_W-1:0] v);
        pause_sender(1);
        while (board.outstanding() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        cfg_wr_en = 1'b1;
        cfg_wr_data = v;
        @(negedge aclk);
        cfg_wr_en = 1'b0;
        board.set_count(v);
    endtask

    task automatic run_phase(input logic [NCOUNT_W-1:0] count, input int items, input bit choke);
        int                  lim;
        int                  burst;
        int                  roll;
        logic [FUNC_W-1:0]   f;
        logic [IDX_W-1:0]    n;
        logic                fv;
        logic [PERIOD_W-1:0] ps;
        write_neuron_count(count);
        lim = (count > NEURONS) ? NEURONS : count;
        burst = choke ? 80 : $urandom_range(1, 24);
        if (choke) begin
            choke_req = 1'b1;
        end
        for (int i = 0; i < items; i++) begin
            roll = $urandom_range(0, 199);
            ps = PERIOD_W'($urandom);
            fv = ($urandom_range(0, 9) < 7);
            if (roll < 100) begin
                f = FUNC_RECORD;
            end else if (roll < 160) begin
                f = FUNC_QUERY;
            end else if (roll < 178) begin
                f = FUNC_DISABLE;
            end else if (roll < 180) begin
                f = FUNC_CLEAR_PERIOD;
            end else begin
                f = FUNC_W'($urandom);
            end
            roll = $urandom_range(0, 99);
            if (roll < 65) begin
                n = hot[$urandom_range(0, 5)];
            end else if (roll < 88 && lim > 0) begin
                n = IDX_W'($urandom_range(0, lim - 1));
            end else begin
                n = IDX_W'($urandom);
            end
            push_op(f, n, fv, ps);
            burst--;
            if (burst == 0) begin
                pause_sender($urandom_range(1, 12));
                burst = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                    : $urandom_range(1, 24);
            end
        end
    endtask

    // receiver: own stall pattern, plus one long hold-off on request
    initial begin
        int mode;
        int left;
        bit held;
        mode = 0;
        left = 0;
        held = 1'b0;
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (choke_req && !held) begin
                held = 1'b1;
                m_ready = 1'b0;
                repeat (400) @(negedge aclk);
            end
            if (left == 0) begin
                mode = $urandom_range(0, 3);
                left = $urandom_range(16, 160);
            end
            left--;
            case (mode)
                0: m_ready = 1'b1;
                1: m_ready = 1'($urandom_range(0, 1));
                2: m_ready = ($urandom_range(0, 4) == 0);
                default: m_ready = (left % 7) < 4;
            endcase
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            board.check_beat(m_out_of_range, m_status_now, m_history_word,
                             m_history_ones, m_period_count);
        end
    end

    initial begin
        #18000000;
        $display("spike_history_recorder_unit_test failed");
        $finish;
    end

    initial begin
        board = new();
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_func = FUNC_RECORD;
        s_neuron_index = '0;
        s_fired_value = 1'b0;
        s_period_select = '0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = '0;
        choke_req = 1'b0;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // directed: edges of each field, every op, count corner cases
        push_op(FUNC_RECORD, 10'd0, 1'b1, 2'd0);
        push_op(FUNC_RECORD, 10'd1023, 1'b1, 2'd3);
        push_op(FUNC_RECORD, 10'd0, 1'b0, 2'd1);
        push_op(FUNC_QUERY, 10'd0, 1'b0, 2'd0);
        push_op(FUNC_QUERY, 10'd0, 1'b1, 2'd1);
        push_op(FUNC_QUERY, 10'd0, 1'b0, 2'd2);
        push_op(FUNC_QUERY, 10'd0, 1'b1, 2'd3);
        push_op(FUNC_QUERY, 10'd1023, 1'b0, 2'd2);
        push_op(FUNC_DISABLE, 10'd0, 1'b1, 2'd0);
        push_op(FUNC_QUERY, 10'd0, 1'b0, 2'd0);
        push_op(FUNC_RECORD, 10'd512, 1'b1, 2'd1);
        push_op(FUNC_RECORD, 10'd512, 1'b1, 2'd2);
        push_op(FUNC_CLEAR_PERIOD, 10'd341, 1'b0, 2'd1);
        push_op(FUNC_QUERY, 10'd512, 1'b0, 2'd1);
        push_op(FUNC_QUERY, 10'd512, 1'b0, 2'd2);
        push_op(FUNC_CLEAR_PERIOD, 10'd1023, 1'b1, 2'd3);
        push_op(FUNC_RECORD, 10'd1023, 1'b1, 2'd3);
        write_neuron_count(11'd1);
        push_op(FUNC_QUERY, 10'd0, 1'b0, 2'd0);
        push_op(FUNC_QUERY, 10'd1, 1'b0, 2'd0);
        push_op(FUNC_RECORD, 10'd1023, 1'b1, 2'd3);
        write_neuron_count(11'd0);
        push_op(FUNC_QUERY, 10'd0, 1'b0, 2'd2);
        push_op(FUNC_CLEAR_PERIOD, 10'd0, 1'b0, 2'd0);
        write_neuron_count(11'd2047);
        push_op(FUNC_QUERY, 10'd1023, 1'b1, 2'd3);
        push_op(FUNC_QUERY, 10'd512, 1'b0, 2'd0);

        run_phase(11'd2047, 400, 1'b1);
        run_phase(11'd1, 100, 1'b0);
        run_phase(11'd0, 50, 1'b0);
        run_phase(11'd1024, 400, 1'b0);
        run_phase(11'd700, 300, 1'b0);
        run_phase(11'd2, 100, 1'b0);
        run_phase(11'd1023, 300, 1'b0);
        run_phase(11'd513, 300, 1'b0);

        pause_sender(1);
        while (board.outstanding() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (board.errors == 0) begin
            $display("spike_history_recorder_unit_test passed");
        end else begin
            $display("spike_history_recorder_unit_test failed");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/shr_pkg.sv
hdl/shr_front.sv
hdl/shr_queue.sv
hdl/shr_back.sv
hdl/spike_history_recorder_unit.sv
tb/spike_history_recorder_unit_test.sv
